[hw/rtl/rpast_pkg.sv]
// Package for the range progression assign / range sum tree.
// Holds sizes, the walk frame type, the state encoding and node helpers.
// No dependencies.
`default_nettype none

package rpast_pkg;

	localparam int LEAVES     = 1024;
	localparam int NODES      = 2 * LEAVES;
	localparam int NODE_W     = $clog2(NODES);
	localparam int POS_W      = 11;
	localparam int VAL_W      = 18;
	localparam int OFF_W      = 20;
	localparam int TAG_W      = OFF_W + 1;
	localparam int SUM_W      = 32;
	localparam int STK_DEPTH  = 32;
	localparam int STK_IDX_W  = $clog2(STK_DEPTH);
	localparam int PROD_W     = 36;
	localparam int MULA_W     = 23;
	localparam int MULB_W     = 13;

	// One pending visit of the tree walk.
	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [POS_W-1:0]  lo;
		logic [POS_W-1:0]  hi;
	} frame_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_POP,
		ST_QACC,
		ST_AMUL,
		ST_AWR,
		ST_PD,
		ST_PDWA,
		ST_PDWB,
		ST_PDCLR,
		ST_PULL,
		ST_PLB,
		ST_PLSUM,
		ST_EMIT
	} state_t;

	// Midpoint of a node's span.
	function automatic logic [POS_W-1:0] mid_of(input logic [POS_W-1:0] lo,
			input logic [POS_W-1:0] hi);
		logic [POS_W:0] s;
		s = {1'b0, lo} + {1'b0, hi};
		return s[POS_W:1];
	endfunction

	// Index of the right child: the left subtree occupies 2*(mid-lo+1)-1 slots.
	function automatic logic [NODE_W-1:0] right_child(input frame_t f);
		logic [POS_W-1:0] m;
		logic [POS_W-1:0] half;
		m = mid_of(f.lo, f.hi);
		half = m - f.lo + 1'b1;
		return f.node + NODE_W'({half, 1'b0});
	endfunction

endpackage

`default_nettype wire

[hw/rtl/rpast_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module rpast_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/range_progression_assign_sum_tree.sv]
// Lazy segment tree: range progression assign and saturating range sum.
// After reset a clearing pass zeroes both memories; no item is taken then.
// An item is taken only in idle and walks the tree one node at a time: a node outside
// the range is only popped, a covered node is summed on a query or written on an assign,
// a split node pushes its children and, if tagged, pushes the tag into both; assigns
// then pull up the split nodes. A query result waits in an output register.
`default_nettype none

module range_progression_assign_sum_tree (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic                        op,
	input  wire logic [rpast_pkg::POS_W-1:0] range_left,
	input  wire logic [rpast_pkg::POS_W-1:0] range_right,
	input  wire logic [rpast_pkg::VAL_W-1:0] start_value,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic      [rpast_pkg::SUM_W-1:0] range_sum
);

	localparam int NW = rpast_pkg::NODE_W;
	localparam int PW = rpast_pkg::POS_W;
	localparam int OW = rpast_pkg::OFF_W;
	localparam int SW = rpast_pkg::SUM_W;
	localparam int XW = rpast_pkg::STK_IDX_W;

	rpast_pkg::state_t state_q, state_d;

	rpast_pkg::frame_t stk [rpast_pkg::STK_DEPTH];
	rpast_pkg::frame_t spl [rpast_pkg::STK_DEPTH];
	logic [XW:0]   sp_q, np_q;
	logic [XW-1:0] sp_top, np_top;
	rpast_pkg::frame_t top_f, spl_f, cur_q, left_f, right_f;
	logic [PW-1:0] cur_mid;

	logic [PW-1:0] ql_q, qr_q, in_ql, in_qr;
	logic          op_q;
	logic [OW-1:0] off_q, pd_off_q, in_off;
	logic [SW-1:0] acc_q, tmp_q, out_sum_q;
	logic          out_valid_q;
	logic [NW-1:0] clr_q;

	logic          top_out, top_full, accept, out_free;

	// Memory ports.
	logic                          tot_we, tag_we;
	logic [NW-1:0]                 tot_waddr, tag_waddr, tot_raddr, tag_raddr;
	logic [SW-1:0]                 tot_wdata, tot_rdata;
	logic [rpast_pkg::TAG_W-1:0]   tag_wdata, tag_rdata;

	// Progression sum unit.
	logic [PW-1:0]                        mul_lo, mul_hi;
	logic [OW-1:0]                        mul_off;
	logic signed [rpast_pkg::MULA_W-1:0]  mul_a;
	logic signed [rpast_pkg::MULB_W-1:0]  mul_b;
	logic signed [rpast_pkg::PROD_W-1:0]  mul_p, prod_q, half;
	logic [SW-1:0]                        span_c;
	logic [SW:0]                          acc_sum, pull_sum;
	logic [SW-1:0]                        acc_sat, pull_sat;

	rpast_ram #(.WIDTH(SW), .DEPTH(rpast_pkg::NODES)) u_tot_ram (
		.clk(clk), .we(tot_we), .waddr(tot_waddr), .wdata(tot_wdata),
		.raddr(tot_raddr), .rdata(tot_rdata)
	);

	rpast_ram #(.WIDTH(rpast_pkg::TAG_W), .DEPTH(rpast_pkg::NODES)) u_tag_ram (
		.clk(clk), .we(tag_we), .waddr(tag_waddr), .wdata(tag_wdata),
		.raddr(tag_raddr), .rdata(tag_rdata)
	);

	// Input clamping and the offset tag of an assign.
	assign in_ql  = (range_left == '0) ? PW'(1) : range_left;
	assign in_qr  = (range_right > PW'(rpast_pkg::LEAVES)) ? PW'(rpast_pkg::LEAVES)
		: range_right;
	assign in_off = OW'({2'b00, start_value}) - OW'(in_ql);

	// Stack tops and the children of the current node.
	assign sp_top  = XW'(sp_q - 1'b1);
	assign np_top  = XW'(np_q - 1'b1);
	assign top_f   = stk[sp_top];
	assign spl_f   = spl[np_top];
	assign cur_mid = rpast_pkg::mid_of(cur_q.lo, cur_q.hi);
	assign left_f  = '{node: NW'(cur_q.node + 1'b1), lo: cur_q.lo, hi: cur_mid};
	assign right_f = '{node: rpast_pkg::right_child(cur_q), lo: PW'(cur_mid + 1'b1),
		hi: cur_q.hi};

	assign top_out  = (top_f.hi < ql_q) || (top_f.lo > qr_q);
	assign top_full = (ql_q <= top_f.lo) && (top_f.hi <= qr_q);

	// Span total: len * (lo + hi + 2*off) / 2, product is always even.
	assign mul_a = $signed({12'b0, mul_lo}) + $signed({12'b0, mul_hi})
		+ $signed({{2{mul_off[OW-1]}}, mul_off, 1'b0});
	assign mul_b = $signed({2'b00, mul_hi}) - $signed({2'b00, mul_lo})
		+ $signed(rpast_pkg::MULB_W'(1));
	assign mul_p = rpast_pkg::PROD_W'(mul_a) * rpast_pkg::PROD_W'(mul_b);
	assign half  = prod_q >>> 1;
	assign span_c = half[rpast_pkg::PROD_W-1] ? '0
		: ((half[rpast_pkg::PROD_W-2:SW] != '0) ? '1 : half[SW-1:0]);

	// Saturating adders for query accumulation and pull-up.
	assign acc_sum  = {1'b0, acc_q} + {1'b0, tot_rdata};
	assign acc_sat  = acc_sum[SW] ? '1 : acc_sum[SW-1:0];
	assign pull_sum = {1'b0, tmp_q} + {1'b0, tot_rdata};
	assign pull_sat = pull_sum[SW] ? '1 : pull_sum[SW-1:0];

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rpast_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory controls and multiplier operands.
	always_comb begin
		state_d   = state_q;
		in_stall  = 1'b1;
		tot_we    = 1'b0;
		tag_we    = 1'b0;
		tot_waddr = cur_q.node;
		tag_waddr = cur_q.node;
		tot_wdata = span_c;
		tag_wdata = {1'b1, off_q};
		tot_raddr = top_f.node;
		tag_raddr = top_f.node;
		mul_lo    = cur_q.lo;
		mul_hi    = cur_q.hi;
		mul_off   = off_q;
		case (state_q)
			rpast_pkg::ST_CLEAR: begin
				tot_we    = 1'b1;
				tag_we    = 1'b1;
				tot_waddr = clr_q;
				tag_waddr = clr_q;
				tot_wdata = '0;
				tag_wdata = '0;
				if (clr_q == NW'(rpast_pkg::NODES - 1)) begin
					state_d = rpast_pkg::ST_IDLE;
				end
			end
			rpast_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_ql <= in_qr) begin
						state_d = rpast_pkg::ST_POP;
					end else if (op) begin
						state_d = rpast_pkg::ST_EMIT;
					end
				end
			end
			rpast_pkg::ST_POP: begin
				if (sp_q == '0) begin
					if (op_q) begin
						state_d = rpast_pkg::ST_EMIT;
					end else if (np_q != '0) begin
						state_d = rpast_pkg::ST_PULL;
					end else begin
						state_d = rpast_pkg::ST_IDLE;
					end
				end else if (top_out) begin
					state_d = rpast_pkg::ST_POP;
				end else if (top_full) begin
					state_d = op_q ? rpast_pkg::ST_QACC : rpast_pkg::ST_AMUL;
				end else begin
					state_d = rpast_pkg::ST_PD;
				end
			end
			rpast_pkg::ST_QACC: begin
				state_d = rpast_pkg::ST_POP;
			end
			rpast_pkg::ST_AMUL: begin
				state_d = rpast_pkg::ST_AWR;
			end
			rpast_pkg::ST_AWR: begin
				tot_we  = 1'b1;
				tag_we  = 1'b1;
				state_d = rpast_pkg::ST_POP;
			end
			rpast_pkg::ST_PD: begin
				mul_hi  = cur_mid;
				mul_off = tag_rdata[OW-1:0];
				state_d = tag_rdata[OW] ? rpast_pkg::ST_PDWA : rpast_pkg::ST_POP;
			end
			rpast_pkg::ST_PDWA: begin
				tot_we    = 1'b1;
				tag_we    = 1'b1;
				tot_waddr = left_f.node;
				tag_waddr = left_f.node;
				tag_wdata = {1'b1, pd_off_q};
				mul_lo    = right_f.lo;
				mul_off   = pd_off_q;
				state_d   = rpast_pkg::ST_PDWB;
			end
			rpast_pkg::ST_PDWB: begin
				tot_we    = 1'b1;
				tag_we    = 1'b1;
				tot_waddr = right_f.node;
				tag_waddr = right_f.node;
				tag_wdata = {1'b1, pd_off_q};
				state_d   = rpast_pkg::ST_PDCLR;
			end
			rpast_pkg::ST_PDCLR: begin
				tag_we    = 1'b1;
				tag_wdata = {1'b0, pd_off_q};
				state_d   = rpast_pkg::ST_POP;
			end
			rpast_pkg::ST_PULL: begin
				tot_raddr = NW'(spl_f.node + 1'b1);
				state_d   = (np_q == '0) ? rpast_pkg::ST_IDLE : rpast_pkg::ST_PLB;
			end
			rpast_pkg::ST_PLB: begin
				tot_raddr = right_f.node;
				state_d   = rpast_pkg::ST_PLSUM;
			end
			rpast_pkg::ST_PLSUM: begin
				tot_we    = 1'b1;
				tot_wdata = pull_sat;
				state_d   = rpast_pkg::ST_PULL;
			end
			rpast_pkg::ST_EMIT: begin
				if (out_free) begin
					state_d = rpast_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rpast_pkg::ST_IDLE;
			end
		endcase
	end

	// Control counters and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q        <= '0;
			np_q        <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == rpast_pkg::ST_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				rpast_pkg::ST_CLEAR: begin
					clr_q <= NW'(clr_q + 1'b1);
				end
				rpast_pkg::ST_IDLE: begin
					if (accept && (in_ql <= in_qr)) begin
						sp_q <= (XW + 1)'(1);
						np_q <= '0;
					end
				end
				rpast_pkg::ST_POP: begin
					if (sp_q != '0) begin
						sp_q <= sp_q - 1'b1;
					end
				end
				rpast_pkg::ST_PD: begin
					sp_q <= sp_q + (XW + 1)'(2);
					np_q <= np_q + 1'b1;
				end
				rpast_pkg::ST_PULL: begin
					if (np_q != '0) begin
						np_q <= np_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Walk payload: stacks, current frame, accumulators.
	always_ff @(posedge clk) begin
		case (state_q)
			rpast_pkg::ST_IDLE: begin
				if (accept) begin
					op_q   <= op;
					ql_q   <= in_ql;
					qr_q   <= in_qr;
					off_q  <= in_off;
					acc_q  <= '0;
					stk[0] <= '{node: '0, lo: PW'(1), hi: PW'(rpast_pkg::LEAVES)};
				end
			end
			rpast_pkg::ST_POP: begin
				cur_q <= top_f;
			end
			rpast_pkg::ST_QACC: begin
				acc_q <= acc_sat;
			end
			rpast_pkg::ST_AMUL: begin
				prod_q <= mul_p;
			end
			rpast_pkg::ST_PD: begin
				stk[sp_q[XW-1:0]]             <= right_f;
				stk[XW'(sp_q[XW-1:0] + 1'b1)] <= left_f;
				spl[np_q[XW-1:0]]             <= cur_q;
				pd_off_q                      <= tag_rdata[OW-1:0];
				prod_q                        <= mul_p;
			end
			rpast_pkg::ST_PDWA: begin
				prod_q <= mul_p;
			end
			rpast_pkg::ST_PULL: begin
				cur_q <= spl_f;
			end
			rpast_pkg::ST_PLB: begin
				tmp_q <= tot_rdata;
			end
			rpast_pkg::ST_EMIT: begin
				if (out_free) begin
					out_sum_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign range_sum = out_sum_q;

	// The walk stack never overflows its storage.
	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= (XW + 1)'(rpast_pkg::STK_DEPTH))
		else $error("walk stack overflow");

	// A result appears only after the emit step.
	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == rpast_pkg::ST_EMIT))
		else $error("result raised outside emit");

	// An item is finished only once its walk stack has drained.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpast_pkg::ST_IDLE) |-> (sp_q == '0))
		else $error("idle with frames left on the stack");

	// Pull-up writes belong to assigns only.
	a_pull_assign: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpast_pkg::ST_PLSUM) |-> !op_q)
		else $error("pull-up during a query");

endmodule

`default_nettype wire

[tb/range_progression_assign_sum_tree_test.sv]
// Testbench for the range progression assign / range sum tree.
// It checks every query sum against a software copy of the lazy segment tree, or against the sum given in the table.
// Depends on rpast_pkg and the range_progression_assign_sum_tree RTL.
`timescale 1ns / 100ps

module range_progression_assign_sum_tree_test;

	localparam logic OP_ASSIGN = 1'b0;
	localparam logic OP_QUERY  = 1'b1;
	localparam int   WALK_MAX  = 128;
	localparam int   IDLE_WAIT = 300;
	localparam int   STUCK_MAX = 20000;
	localparam longint SAT    = 64'hFFFF_FFFF;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             op = OP_ASSIGN;
	logic [rpast_pkg::POS_W-1:0]      range_left = '0;
	logic [rpast_pkg::POS_W-1:0]      range_right = '0;
	logic [rpast_pkg::VAL_W-1:0]      start_value = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [rpast_pkg::SUM_W-1:0]      range_sum;

	range_progression_assign_sum_tree dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .range_left(range_left), .range_right(range_right),
		.start_value(start_value),
		.out_valid(out_valid), .out_stall(out_stall), .range_sum(range_sum)
	);

	// Shadow copy of the tree: node sums, tag offsets and tag flags.
	logic [rpast_pkg::SUM_W-1:0] tree_sum [rpast_pkg::NODES];
	int                          tree_off [rpast_pkg::NODES];
	bit                          tree_tagged [rpast_pkg::NODES];

	logic [rpast_pkg::SUM_W-1:0] sums_due [$];
	int  mismatches = 0;
	bit  failed = 1'b0;
	int  idle_pct = 0;
	int  stall_pct = 0;
	int  hold_left = 0;
	int  stuck = 0;

	// Sum of positions lo..hi each shifted by off, clamped to 32 bits.
	function automatic logic [rpast_pkg::SUM_W-1:0] span_value(int lo, int hi, int off);
		longint len;
		longint s;
		len = hi - lo + 1;
		s = (longint'(lo) + hi) * len / 2 + longint'(off) * len;
		if (s < 0)
			return '0;
		if (s > SAT)
			return SAT[rpast_pkg::SUM_W-1:0];
		return s[rpast_pkg::SUM_W-1:0];
	endfunction

	function automatic void set_tag(int n, int lo, int hi, int off);
		if (n >= rpast_pkg::NODES)
			return;
		tree_sum[n] = span_value(lo, hi, off);
		tree_off[n] = off;
		tree_tagged[n] = 1'b1;
	endfunction

	// Walks the tree over ql..qr; assigns the offset or returns the range sum.
	function automatic logic [rpast_pkg::SUM_W-1:0] tree_walk(bit is_assign, int ql, int qr,
			int off);
		int sn [WALK_MAX];
		int slo [WALK_MAX];
		int shi [WALK_MAX];
		int pn [WALK_MAX];
		int plo [WALK_MAX];
		int phi [WALK_MAX];
		int sp;
		int np;
		int n;
		int lo;
		int hi;
		int mid;
		int a;
		int b;
		longint acc;
		sp = 1;
		np = 0;
		acc = 0;
		sn[0] = 0;
		slo[0] = 1;
		shi[0] = rpast_pkg::LEAVES;
		while (sp > 0) begin
			sp--;
			n = sn[sp];
			lo = slo[sp];
			hi = shi[sp];
			if (n >= rpast_pkg::NODES || hi < ql || lo > qr)
				continue;
			mid = (lo + hi) >> 1;
			if (ql <= lo && hi <= qr) begin
				if (is_assign)
					set_tag(n, lo, hi, off);
				else begin
					acc += tree_sum[n];
					if (acc > SAT)
						acc = SAT;
				end
				continue;
			end
			// Push a pending tag into both children.
			if (tree_tagged[n] && lo < hi) begin
				set_tag(n + 1, lo, mid, tree_off[n]);
				set_tag(n + 2 * (mid - lo + 1), mid + 1, hi, tree_off[n]);
				tree_tagged[n] = 1'b0;
			end
			if (np < WALK_MAX) begin
				pn[np] = n;
				plo[np] = lo;
				phi[np] = hi;
				np++;
			end
			if (sp + 2 > WALK_MAX)
				continue;
			sn[sp] = n + 2 * (mid - lo + 1);
			slo[sp] = mid + 1;
			shi[sp] = hi;
			sn[sp + 1] = n + 1;
			slo[sp + 1] = lo;
			shi[sp + 1] = mid;
			sp += 2;
		end
		// Rebuild the sums of split nodes, deepest first.
		if (is_assign) begin
			while (np > 0) begin
				np--;
				mid = (plo[np] + phi[np]) >> 1;
				a = pn[np] + 1;
				b = pn[np] + 2 * (mid - plo[np] + 1);
				if (pn[np] >= rpast_pkg::NODES || a >= rpast_pkg::NODES
						|| b >= rpast_pkg::NODES)
					continue;
				acc = longint'(tree_sum[a]) + tree_sum[b];
				tree_sum[pn[np]] = (acc > SAT) ? SAT[rpast_pkg::SUM_W-1:0]
					: acc[rpast_pkg::SUM_W-1:0];
			end
			return '0;
		end
		return acc[rpast_pkg::SUM_W-1:0];
	endfunction

	// Applies one accepted transaction; returns 1 with the sum for a query.
	function automatic bit tree_apply(logic o, int l, int r, int k,
			output logic [rpast_pkg::SUM_W-1:0] s);
		s = '0;
		if (l == 0)
			l = 1;
		if (r > rpast_pkg::LEAVES)
			r = rpast_pkg::LEAVES;
		if (o == OP_ASSIGN) begin
			if (l <= r)
				void'(tree_walk(1'b1, l, r, k - l));
			return 1'b0;
		end
		if (l <= r)
			s = tree_walk(1'b0, l, r, 0);
		return 1'b1;
	endfunction

	// Clock.
	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off when requested.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Result checker and watchdog.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck <= 0;
		else
			stuck <= stuck + 1;
		if (out_valid && !out_stall) begin
			if (sums_due.size() == 0) begin
				failed = 1'b1;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction: range_sum %0d", range_sum);
			end else begin
				if (range_sum !== sums_due[0]) begin
					failed = 1'b1;
					mismatches++;
					if (mismatches <= 10)
						$display("range_sum mismatch: expected %0d, got %0d",
							sums_due[0], range_sum);
				end
				void'(sums_due.pop_front());
			end
		end
		if (stuck >= STUCK_MAX) begin
			$display("simulation failed");
			$finish;
		end
	end

	typedef struct {
		logic       o;
		int         l;
		int         r;
		int         k;
		bit         known;
		logic [31:0] want;
	} row_t;

	// Drives one transaction and waits for it to be accepted.
	task automatic send_item(logic o, int l, int r, int k, bit known, logic [31:0] want);
		logic [rpast_pkg::SUM_W-1:0] s;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		range_left <= l[rpast_pkg::POS_W-1:0];
		range_right <= r[rpast_pkg::POS_W-1:0];
		start_value <= k[rpast_pkg::VAL_W-1:0];
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (tree_apply(o, l, r, k, s))
			sums_due.push_back(known ? want : s);
	endtask

	// Waits until every query sum has come back, then lets the walk settle.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sums_due.size() != 0)
			@(posedge clk);
		repeat (IDLE_WAIT) @(posedge clk);
	endtask

	task automatic random_item();
		int l;
		int r;
		int pick;
		logic o;
		int k;
		pick = $urandom_range(99);
		if (pick < 10) begin
			l = $urandom_range(2047);
			r = $urandom_range(2047);
		end else if (pick < 40) begin
			l = $urandom_range(1, rpast_pkg::LEAVES);
			r = l + $urandom_range(7);
		end else begin
			l = $urandom_range(1, rpast_pkg::LEAVES);
			r = $urandom_range(l, rpast_pkg::LEAVES);
		end
		o = 1'($urandom_range(1));
		k = int'($urandom_range(262143));
		send_item(o, l, r, k, 1'b0, '0);
	endtask

	row_t steps [] = '{
		'{OP_QUERY,  1,    1024, 0,      1'b1, 32'd0},
		'{OP_QUERY,  0,    2047, 0,      1'b1, 32'd0},
		'{OP_ASSIGN, 1,    1024, 0,      1'b0, 32'd0},
		'{OP_QUERY,  1,    1024, 0,      1'b1, 32'd523776},
		'{OP_QUERY,  0,    2047, 5,      1'b1, 32'd523776},
		'{OP_QUERY,  1,    1,    0,      1'b1, 32'd0},
		'{OP_QUERY,  1024, 1024, 0,      1'b1, 32'd1023},
		'{OP_QUERY,  5,    3,    0,      1'b1, 32'd0},
		'{OP_QUERY,  1025, 2047, 0,      1'b1, 32'd0},
		'{OP_ASSIGN, 0,    0,    7,      1'b0, 32'd0},
		'{OP_ASSIGN, 9,    2,    99,     1'b0, 32'd0},
		'{OP_QUERY,  1,    1024, 0,      1'b1, 32'd523776},
		'{OP_ASSIGN, 1,    1024, 262143, 1'b0, 32'd0},
		'{OP_QUERY,  1,    1024, 0,      1'b1, 32'd268958208},
		'{OP_ASSIGN, 0,    3,    10,     1'b0, 32'd0},
		'{OP_QUERY,  1,    3,    0,      1'b0, 32'd0},
		'{OP_ASSIGN, 300,  700,  1,      1'b0, 32'd0},
		'{OP_QUERY,  250,  512,  0,      1'b0, 32'd0},
		'{OP_ASSIGN, 1000, 2047, 0,      1'b0, 32'd0},
		'{OP_QUERY,  990,  1024, 0,      1'b0, 32'd0},
		'{OP_ASSIGN, 513,  513,  131072, 1'b0, 32'd0},
		'{OP_QUERY,  512,  514,  0,      1'b0, 32'd0},
		'{OP_QUERY,  2047, 0,    0,      1'b1, 32'd0}
	};

	// Main sequence: reset, directed table, then random phases.
	initial begin
		for (int i = 0; i < rpast_pkg::NODES; i++) begin
			tree_sum[i] = '0;
			tree_off[i] = 0;
			tree_tagged[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		foreach (steps[i])
			send_item(steps[i].o, steps[i].l, steps[i].r, steps[i].k,
				steps[i].known, steps[i].want);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 64 : 38) : 0;
			stall_pct = (ph == 2) ? 64 : ((ph == 3) ? 38 : 0);
			for (int i = 0; i < 100; i++) begin
				// Long receiver hold-off while the sender keeps offering.
				if (ph == 0 && i == 50)
					hold_left = 1500;
				random_item();
			end
			// The sender pauses until every sum has come back.
			drain();
		end
		if (!failed && sums_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/rpast_pkg.sv
hw/rtl/rpast_ram.sv
hw/rtl/range_progression_assign_sum_tree.sv
tb/range_progression_assign_sum_tree_test.sv
